/* rtl/gasp_pkg.sv */
// ----------------------------------------------------------------------------
// gasp_pkg: shared types and constants for the grid A* path search
// Grid geometry, cost widths, operation and mark codes, memory request types.
// ----------------------------------------------------------------------------
package gasp_pkg;

  localparam int GRID_SIDE = 64;
  localparam int COORD_W   = $clog2(GRID_SIDE);
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int NODE_W    = $clog2(CELLS);
  localparam int CNT_W     = NODE_W + 1;
  localparam int DIM_W     = 7;
  localparam int COST_W    = 21;
  localparam int STEP_COST = 10;
  localparam int H_WEIGHT  = 10;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] MARK_NONE   = 2'd0;
  localparam logic [1:0] MARK_OPEN   = 2'd1;
  localparam logic [1:0] MARK_CLOSED = 2'd2;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0] parent;
    logic [COST_W-1:0] g;
    logic [COST_W-1:0] f;
  } node_t;

  typedef struct packed {
    logic              blk_we;
    logic [NODE_W-1:0] blk_waddr;
    logic              blk_wdata;
    logic [NODE_W-1:0] blk_raddr;
    logic              mark_we;
    logic [NODE_W-1:0] mark_waddr;
    logic [1:0]        mark_wdata;
    logic [NODE_W-1:0] mark_raddr;
    logic              node_we;
    logic [NODE_W-1:0] node_waddr;
    node_t             node_wdata;
    logic [NODE_W-1:0] node_raddr;
    logic              ol_we;
    logic [NODE_W-1:0] ol_waddr;
    logic [NODE_W-1:0] ol_wdata;
    logic [NODE_W-1:0] ol_raddr;
    logic              ps_we;
    logic [NODE_W-1:0] ps_waddr;
    logic [NODE_W-1:0] ps_wdata;
    logic [NODE_W-1:0] ps_raddr;
  } mem_req_t;

  typedef struct packed {
    logic              blk;
    logic [1:0]        mark;
    node_t             node;
    logic [NODE_W-1:0] ol;
    logic [NODE_W-1:0] ps;
  } mem_rsp_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(GRID_SIDE)) r = DIM_W'(GRID_SIDE);
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [COST_W-1:0] h_cost(input logic [NODE_W-1:0] n,
                                               input logic [COORD_W-1:0] gx,
                                               input logic [COORD_W-1:0] gy);
    logic [COORD_W:0] sum;
    sum = {1'b0, absdiff(n[COORD_W-1:0], gx)} + {1'b0, absdiff(n[NODE_W-1:COORD_W], gy)};
    return COST_W'(sum) * COST_W'(H_WEIGHT);
  endfunction

endpackage

/* rtl/gasp_store.sv */
// ----------------------------------------------------------------------------
// gasp_store: node memories of the path search
// Blocked map, open/closed marks, node costs and parents, open list and path,
// each a simple dual-port memory with registered read data.
// ----------------------------------------------------------------------------
module gasp_store import gasp_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  logic              blk_mem  [CELLS];
  logic [1:0]        mark_mem [CELLS];
  node_t             node_mem [CELLS];
  logic [NODE_W-1:0] ol_mem   [CELLS];
  logic [NODE_W-1:0] ps_mem   [CELLS];

  always_ff @(posedge clk) begin
    if (req.blk_we) blk_mem[req.blk_waddr] <= req.blk_wdata;
    if (req.mark_we) mark_mem[req.mark_waddr] <= req.mark_wdata;
    if (req.node_we) node_mem[req.node_waddr] <= req.node_wdata;
    if (req.ol_we) ol_mem[req.ol_waddr] <= req.ol_wdata;
    if (req.ps_we) ps_mem[req.ps_waddr] <= req.ps_wdata;
  end

  always_ff @(posedge clk) begin
    rsp.blk  <= blk_mem[req.blk_raddr];
    rsp.mark <= mark_mem[req.mark_raddr];
    rsp.node <= node_mem[req.node_raddr];
    rsp.ol   <= ol_mem[req.ol_raddr];
    rsp.ps   <= ps_mem[req.ps_raddr];
  end

endmodule

/* rtl/gasp_seq.sv */
// ----------------------------------------------------------------------------
// gasp_seq: request sequencer of the path search
// Decodes requests, runs the A* loop over the node memories and returns
// one registered result per request.
// ----------------------------------------------------------------------------
module gasp_seq import gasp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic [COORD_W-1:0] in_x,
  input  logic [COORD_W-1:0] in_y,
  input  logic [COORD_W-1:0] in_goal_x,
  input  logic [COORD_W-1:0] in_goal_y,
  input  logic               in_blocked,
  input  logic [NODE_W-1:0]  in_path_index,
  input  logic [DIM_W-1:0]   map_w,
  input  logic [DIM_W-1:0]   map_h,
  output logic               out_valid,
  output logic               out_found,
  output logic [CNT_W-1:0]   out_path_length,
  output logic [COORD_W-1:0] out_point_x,
  output logic [COORD_W-1:0] out_point_y,
  output logic               out_point_valid,
  output mem_req_t           req,
  input  mem_rsp_t           rsp
);

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_READ     = 17'h00002,
    S_CLEAR    = 17'h00004,
    S_SETUP    = 17'h00008,
    S_SC_RD    = 17'h00010,
    S_SC_NODE  = 17'h00020,
    S_SC_CMP   = 17'h00040,
    S_SEL      = 17'h00080,
    S_REM_RD   = 17'h00100,
    S_REM_WR   = 17'h00200,
    S_CUR_G    = 17'h00400,
    S_NB_ISSUE = 17'h00800,
    S_NB_EVAL  = 17'h01000,
    S_WALK_RD  = 17'h02000,
    S_WALK_WR  = 17'h04000,
    S_DONE     = 17'h08000,
    S_INIT     = 17'h10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [COORD_W-1:0] gx_r, gx_nxt, gy_r, gy_nxt;
  logic [NODE_W-1:0]  s_node_r, s_node_nxt, g_node_r, g_node_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, p_r, p_nxt, len_r, len_nxt;
  logic [NODE_W-1:0]  pos_r, pos_nxt, best_node_r, best_node_nxt;
  logic [COST_W-1:0]  best_f_r, best_f_nxt, gcur_r, gcur_nxt;
  logic [NODE_W-1:0]  sc_node_r, sc_node_nxt, cur_r, cur_nxt, nb_r, nb_nxt;
  logic [NODE_W-1:0]  n_r, n_nxt;
  logic [1:0]         dir_r, dir_nxt;

  logic               out_valid_r, out_valid_nxt, pv_r, pv_nxt;
  logic [COORD_W-1:0] px_r, px_nxt, py_r, py_nxt;

  // neighbor of the current node in the present direction
  logic [COORD_W-1:0] cx, cy;
  logic [COORD_W:0]   nx, ny;
  logic               nb_in;
  logic [NODE_W-1:0]  nb;
  logic [COST_W-1:0]  ng;
  node_t              nb_entry;
  logic               nb_skip;

  always_comb begin
    cx = cur_r[COORD_W-1:0];
    cy = cur_r[NODE_W-1:COORD_W];
    nx = {1'b0, cx};
    ny = {1'b0, cy};
    nb_in = 1'b0;
    case (dir_r)
      2'd0: begin
        ny = {1'b0, cy} - 1'b1;
        nb_in = (cy != '0);
      end
      2'd1: begin
        nx = {1'b0, cx} + 1'b1;
        nb_in = (nx < map_w);
      end
      2'd2: begin
        ny = {1'b0, cy} + 1'b1;
        nb_in = (ny < map_h);
      end
      default: begin
        nx = {1'b0, cx} - 1'b1;
        nb_in = (cx != '0);
      end
    endcase
    nb = {ny[COORD_W-1:0], nx[COORD_W-1:0]};
    ng = gcur_r + COST_W'(STEP_COST);
    nb_entry.parent = cur_r;
    nb_entry.g = ng;
    nb_entry.f = ng + h_cost(nb_r, gx_r, gy_r);
    nb_skip = (rsp.blk && nb_r != s_node_r && nb_r != g_node_r) || rsp.mark == MARK_CLOSED;
  end

  always_comb begin
    state_nxt = state_r;
    gx_nxt = gx_r;
    gy_nxt = gy_r;
    s_node_nxt = s_node_r;
    g_node_nxt = g_node_r;
    cnt_nxt = cnt_r;
    p_nxt = p_r;
    len_nxt = len_r;
    pos_nxt = pos_r;
    best_node_nxt = best_node_r;
    best_f_nxt = best_f_r;
    gcur_nxt = gcur_r;
    sc_node_nxt = sc_node_r;
    cur_nxt = cur_r;
    nb_nxt = nb_r;
    n_nxt = n_r;
    dir_nxt = dir_r;
    out_valid_nxt = 1'b0;
    pv_nxt = 1'b0;
    px_nxt = '0;
    py_nxt = '0;
    req = '0;

    case (state_r)
      S_INIT: begin
        // sweep the blocked map clear once after reset
        req.blk_we = 1'b1;
        req.blk_waddr = p_r[NODE_W-1:0];
        req.blk_wdata = 1'b0;
        p_nxt = p_r + 1'b1;
        if (p_r == CNT_W'(CELLS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          case (in_op)
            OP_SEARCH: begin
              len_nxt = '0;
              if ({1'b0, in_x} >= map_w || {1'b0, in_y} >= map_h ||
                  {1'b0, in_goal_x} >= map_w || {1'b0, in_goal_y} >= map_h ||
                  (in_x == in_goal_x && in_y == in_goal_y)) begin
                state_nxt = S_DONE;
              end else begin
                s_node_nxt = {in_y, in_x};
                g_node_nxt = {in_goal_y, in_goal_x};
                gx_nxt = in_goal_x;
                gy_nxt = in_goal_y;
                p_nxt = '0;
                state_nxt = S_CLEAR;
              end
            end
            OP_READ: begin
              if ({1'b0, in_path_index} < len_r) begin
                req.ps_raddr = NODE_W'(len_r - CNT_W'(1) - {1'b0, in_path_index});
                state_nxt = S_READ;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              // tile write; the unused op code also lands here without the write
              req.blk_we = (in_op == OP_WRITE);
              req.blk_waddr = {in_y, in_x};
              req.blk_wdata = in_blocked;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        pv_nxt = 1'b1;
        px_nxt = rsp.ps[COORD_W-1:0];
        py_nxt = rsp.ps[NODE_W-1:COORD_W];
        state_nxt = S_IDLE;
      end
      S_CLEAR: begin
        req.mark_we = 1'b1;
        req.mark_waddr = p_r[NODE_W-1:0];
        req.mark_wdata = MARK_NONE;
        p_nxt = p_r + 1'b1;
        if (p_r == CNT_W'(CELLS - 1)) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        req.node_we = 1'b1;
        req.node_waddr = s_node_r;
        req.node_wdata = '{parent: s_node_r, g: '0, f: '0};
        req.ol_we = 1'b1;
        req.ol_waddr = '0;
        req.ol_wdata = s_node_r;
        req.mark_we = 1'b1;
        req.mark_waddr = s_node_r;
        req.mark_wdata = MARK_OPEN;
        cnt_nxt = CNT_W'(1);
        p_nxt = '0;
        state_nxt = S_SC_RD;
      end
      S_SC_RD: begin
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          req.ol_raddr = p_r[NODE_W-1:0];
          state_nxt = S_SC_NODE;
        end
      end
      S_SC_NODE: begin
        req.node_raddr = rsp.ol;
        sc_node_nxt = rsp.ol;
        state_nxt = S_SC_CMP;
      end
      S_SC_CMP: begin
        // strict compare keeps the first entry on ties
        if (p_r == '0 || rsp.node.f < best_f_r) begin
          best_f_nxt = rsp.node.f;
          best_node_nxt = sc_node_r;
          pos_nxt = p_r[NODE_W-1:0];
        end
        p_nxt = p_r + 1'b1;
        state_nxt = (p_r + 1'b1 == cnt_r) ? S_SEL : S_SC_RD;
      end
      S_SEL: begin
        if (best_node_r == g_node_r) begin
          req.ps_we = 1'b1;
          req.ps_waddr = '0;
          req.ps_wdata = g_node_r;
          p_nxt = CNT_W'(1);
          n_nxt = g_node_r;
          state_nxt = S_WALK_RD;
        end else begin
          state_nxt = S_REM_RD;
        end
      end
      S_REM_RD: begin
        req.ol_raddr = NODE_W'(cnt_r - 1'b1);
        state_nxt = S_REM_WR;
      end
      S_REM_WR: begin
        // swap the last entry into the freed slot and close the node
        req.ol_we = 1'b1;
        req.ol_waddr = pos_r;
        req.ol_wdata = rsp.ol;
        cnt_nxt = cnt_r - 1'b1;
        req.mark_we = 1'b1;
        req.mark_waddr = best_node_r;
        req.mark_wdata = MARK_CLOSED;
        cur_nxt = best_node_r;
        req.node_raddr = best_node_r;
        state_nxt = S_CUR_G;
      end
      S_CUR_G: begin
        gcur_nxt = rsp.node.g;
        dir_nxt = '0;
        state_nxt = S_NB_ISSUE;
      end
      S_NB_ISSUE: begin
        if (nb_in) begin
          req.blk_raddr = nb;
          req.mark_raddr = nb;
          req.node_raddr = nb;
          nb_nxt = nb;
          state_nxt = S_NB_EVAL;
        end else if (dir_r == 2'd3) begin
          p_nxt = '0;
          state_nxt = S_SC_RD;
        end else begin
          dir_nxt = dir_r + 1'b1;
        end
      end
      S_NB_EVAL: begin
        if (!nb_skip) begin
          if (rsp.mark == MARK_OPEN) begin
            if (ng < rsp.node.g) begin
              req.node_we = 1'b1;
              req.node_waddr = nb_r;
              req.node_wdata = nb_entry;
            end
          end else if (cnt_r != CNT_W'(CELLS)) begin
            req.ol_we = 1'b1;
            req.ol_waddr = cnt_r[NODE_W-1:0];
            req.ol_wdata = nb_r;
            cnt_nxt = cnt_r + 1'b1;
            req.mark_we = 1'b1;
            req.mark_waddr = nb_r;
            req.mark_wdata = MARK_OPEN;
            req.node_we = 1'b1;
            req.node_waddr = nb_r;
            req.node_wdata = nb_entry;
          end
        end
        if (dir_r == 2'd3) begin
          p_nxt = '0;
          state_nxt = S_SC_RD;
        end else begin
          dir_nxt = dir_r + 1'b1;
          state_nxt = S_NB_ISSUE;
        end
      end
      S_WALK_RD: begin
        // path is stored goal first; reads index it from the end
        if (n_r == s_node_r || p_r == CNT_W'(CELLS)) begin
          len_nxt = p_r;
          state_nxt = S_DONE;
        end else begin
          req.node_raddr = n_r;
          state_nxt = S_WALK_WR;
        end
      end
      S_WALK_WR: begin
        n_nxt = rsp.node.parent;
        req.ps_we = 1'b1;
        req.ps_waddr = p_r[NODE_W-1:0];
        req.ps_wdata = rsp.node.parent;
        p_nxt = p_r + 1'b1;
        state_nxt = S_WALK_RD;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      len_r <= '0;
      cnt_r <= '0;
      p_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r <= len_nxt;
      cnt_r <= cnt_nxt;
      p_r <= p_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gx_r <= gx_nxt;
    gy_r <= gy_nxt;
    s_node_r <= s_node_nxt;
    g_node_r <= g_node_nxt;
    pos_r <= pos_nxt;
    best_node_r <= best_node_nxt;
    best_f_r <= best_f_nxt;
    gcur_r <= gcur_nxt;
    sc_node_r <= sc_node_nxt;
    cur_r <= cur_nxt;
    nb_r <= nb_nxt;
    n_r <= n_nxt;
    dir_r <= dir_nxt;
    pv_r <= pv_nxt;
    px_r <= px_nxt;
    py_r <= py_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_found = (len_r != '0);
  assign out_path_length = len_r;
  assign out_point_x = px_r;
  assign out_point_y = py_r;
  assign out_point_valid = pv_r;

endmodule

/* rtl/grid_astar_path_search.sv */
// ----------------------------------------------------------------------------
// grid_astar_path_search: four-connected A* search on a blocked-tile grid
// Holds the map size registers and joins the sequencer to the node memories.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with in_op and its fields; the request is taken when busy is
//   low. in_op 0 writes a tile's blocked bit, 1 runs a search from (in_x,in_y)
//   to (in_goal_x,in_goal_y), 2 reads one point of the last found path.
//   Every request returns one result, marked by out_valid for one cycle.
//   For a tile write the result follows in the next cycle and a new request
//   may come at once. A path read makes one path memory read. A search first
//   sweeps the mark memory, then for each node it expands scans every
//   open-list entry and evaluates each neighbor, and it walks the parent chain
//   to store the path; the open-list scan through the single memory port sets
//   the pace. Searches rejected up front (start equals goal, tile off the map)
//   skip the sweep and go straight to the done state.
//   cfg_we writes map width (index 0) or height (index 1); write it only while
//   idle, which the block does not enforce. Reset empties the stored path and
//   sets the map to 64 by 64; busy then stays high while the blocked map is
//   swept clear, so every tile starts walkable. Results cannot be stalled.
// ----------------------------------------------------------------------------
module grid_astar_path_search import gasp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic [COORD_W-1:0] in_x,
  input  logic [COORD_W-1:0] in_y,
  input  logic [COORD_W-1:0] in_goal_x,
  input  logic [COORD_W-1:0] in_goal_y,
  input  logic               in_blocked,
  input  logic [NODE_W-1:0]  in_path_index,
  output logic               out_valid,
  output logic               out_found,
  output logic [CNT_W-1:0]   out_path_length,
  output logic [COORD_W-1:0] out_point_x,
  output logic [COORD_W-1:0] out_point_y,
  output logic               out_point_valid,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [DIM_W-1:0]   cfg_wdata
);

  logic [DIM_W-1:0] map_w_r, map_w_nxt, map_h_r, map_h_nxt;
  mem_req_t         req;
  mem_rsp_t         rsp;

  always_comb begin
    map_w_nxt = map_w_r;
    map_h_nxt = map_h_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  map_w_nxt = clamp_dim(cfg_wdata);
        CFG_HEIGHT: map_h_nxt = clamp_dim(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r <= DIM_W'(GRID_SIDE);
      map_h_r <= DIM_W'(GRID_SIDE);
    end else begin
      map_w_r <= map_w_nxt;
      map_h_r <= map_h_nxt;
    end
  end

  gasp_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_x            (in_x),
    .in_y            (in_y),
    .in_goal_x       (in_goal_x),
    .in_goal_y       (in_goal_y),
    .in_blocked      (in_blocked),
    .in_path_index   (in_path_index),
    .map_w           (map_w_r),
    .map_h           (map_h_r),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_path_length (out_path_length),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_valid (out_point_valid),
    .req             (req),
    .rsp             (rsp)
  );

  gasp_store u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

endmodule

/* tb/grid_astar_path_search_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_astar_path_search_tb: self-checking bench for the grid A* path search
// Drives tile writes, searches and path reads through the command port and
// checks every result against an in-bench predictor of the search, over
// several map sizes, with random gaps between requests.
// ----------------------------------------------------------------------------
module grid_astar_path_search_tb;
  import gasp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 60000000;

  typedef struct {
    logic               found;
    logic [CNT_W-1:0]   len;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               pv;
  } path_result_t;

  class path_scoreboard;
    bit   blk[CELLS];
    bit   open_m[CELLS];
    bit   closed_m[CELLS];
    int   g_of[CELLS];
    int   f_of[CELLS];
    int   parent[CELLS];
    int   open_q[CELLS];
    int   open_n;
    int   path[$];
    int   map_w = GRID_SIDE;
    int   map_h = GRID_SIDE;
    path_result_t expected_q[$];
    int   errors;
    int   searches;
    int   found_paths;
    int   valid_reads;

    function void set_dim(logic idx, logic [DIM_W-1:0] v);
      int d;
      d = (v == 0) ? 1 : ((v > GRID_SIDE) ? GRID_SIDE : int'(v));
      if (idx == CFG_WIDTH) map_w = d;
      else map_h = d;
    endfunction

    function int manhattan10(int n, int gx, int gy);
      int dx, dy;
      dx = n % GRID_SIDE - gx;
      dy = n / GRID_SIDE - gy;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return H_WEIGHT * (dx + dy);
    endfunction

    function void search(int sx, int sy, int gx, int gy);
      int dxs[4];
      int dys[4];
      int s, g, pos, cur, nx, ny, nb, ng, n;
      bit reached;
      dxs = '{0, 1, 0, -1};
      dys = '{-1, 0, 1, 0};
      path.delete();
      reached = 0;
      searches++;
      if (sx >= map_w || sy >= map_h || gx >= map_w || gy >= map_h) return;
      if (sx == gx && sy == gy) return;
      foreach (open_m[i]) begin
        open_m[i] = 0;
        closed_m[i] = 0;
      end
      s = sy * GRID_SIDE + sx;
      g = gy * GRID_SIDE + gx;
      g_of[s] = 0;
      f_of[s] = 0;
      open_q[0] = s;
      open_m[s] = 1;
      open_n = 1;
      while (open_n > 0) begin
        // lowest F wins, first in list order on ties
        pos = 0;
        for (int p = 1; p < open_n; p++)
          if (f_of[open_q[p]] < f_of[open_q[pos]]) pos = p;
        cur = open_q[pos];
        if (cur == g) begin
          reached = 1;
          break;
        end
        open_q[pos] = open_q[open_n - 1];
        open_n--;
        open_m[cur] = 0;
        closed_m[cur] = 1;
        for (int d = 0; d < 4; d++) begin
          nx = cur % GRID_SIDE + dxs[d];
          ny = cur / GRID_SIDE + dys[d];
          if (nx < 0 || ny < 0 || nx >= map_w || ny >= map_h) continue;
          nb = ny * GRID_SIDE + nx;
          if (blk[nb] && nb != s && nb != g) continue;
          if (closed_m[nb]) continue;
          ng = g_of[cur] + STEP_COST;
          if (open_m[nb]) begin
            if (ng < g_of[nb]) begin
              parent[nb] = cur;
              g_of[nb] = ng;
              f_of[nb] = ng + manhattan10(nb, gx, gy);
            end
          end else begin
            open_q[open_n++] = nb;
            open_m[nb] = 1;
            parent[nb] = cur;
            g_of[nb] = ng;
            f_of[nb] = ng + manhattan10(nb, gx, gy);
          end
        end
      end
      if (!reached) return;
      // walk the parent chain back so that point 0 is the start
      n = g;
      path.push_front(g);
      while (n != s && path.size() < CELLS) begin
        n = parent[n];
        path.push_front(n);
      end
      found_paths++;
    endfunction

    function void note_request(logic [1:0] op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                               logic [COORD_W-1:0] gx, logic [COORD_W-1:0] gy, logic b,
                               logic [NODE_W-1:0] pi);
      path_result_t e;
      e.px = '0;
      e.py = '0;
      e.pv = 1'b0;
      if (op == OP_WRITE) begin
        blk[{y, x}] = b;
      end else if (op == OP_SEARCH) begin
        search(x, y, gx, gy);
      end else if (op == OP_READ) begin
        if (pi < path.size()) begin
          e.px = COORD_W'(path[pi] % GRID_SIDE);
          e.py = COORD_W'(path[pi] / GRID_SIDE);
          e.pv = 1'b1;
          valid_reads++;
        end
      end
      e.found = (path.size() != 0);
      e.len = CNT_W'(path.size());
      expected_q.push_back(e);
    endfunction

    function void check_result(path_result_t act);
      path_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no request pending: found %0d len %0d", $time,
                 act.found, act.len);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (act.found !== e.found) begin
        $display("%0t: found exp %0d act %0d", $time, e.found, act.found);
        errors++;
      end
      if (act.len !== e.len) begin
        $display("%0t: path_length exp %0d act %0d", $time, e.len, act.len);
        errors++;
      end
      if (act.px !== e.px) begin
        $display("%0t: point_x exp %0d act %0d", $time, e.px, act.px);
        errors++;
      end
      if (act.py !== e.py) begin
        $display("%0t: point_y exp %0d act %0d", $time, e.py, act.py);
        errors++;
      end
      if (act.pv !== e.pv) begin
        $display("%0t: point_valid exp %0d act %0d", $time, e.pv, act.pv);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_op;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic [COORD_W-1:0] in_goal_x;
  logic [COORD_W-1:0] in_goal_y;
  logic               in_blocked;
  logic [NODE_W-1:0]  in_path_index;
  logic               out_valid;
  logic               out_found;
  logic [CNT_W-1:0]   out_path_length;
  logic [COORD_W-1:0] out_point_x;
  logic [COORD_W-1:0] out_point_y;
  logic               out_point_valid;
  logic               cfg_we;
  logic               cfg_index;
  logic [DIM_W-1:0]   cfg_wdata;

  path_scoreboard sb = new();
  bit idle_on;
  int quiet_cycles;

  grid_astar_path_search i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_x           (in_x),
    .in_y           (in_y),
    .in_goal_x      (in_goal_x),
    .in_goal_y      (in_goal_y),
    .in_blocked     (in_blocked),
    .in_path_index  (in_path_index),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_path_length(out_path_length),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_point_valid(out_point_valid),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    path_result_t act;
    if (rst_n && out_valid) begin
      act.found = out_found;
      act.len = out_path_length;
      act.px = out_point_x;
      act.py = out_point_y;
      act.pv = out_point_valid;
      sb.check_result(act);
    end
  end

  // count cycles in which no request is taken and no result comes
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("grid_astar_path_search test failed");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] gx,
                              input logic [COORD_W-1:0] gy, input logic b,
                              input logic [NODE_W-1:0] pi);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_op         <= op;
    in_x          <= x;
    in_y          <= y;
    in_goal_x     <= gx;
    in_goal_y     <= gy;
    in_blocked    <= b;
    in_path_index <= pi;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(op, x, y, gx, gy, b, pi);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_dim(input logic idx, input logic [DIM_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_dim(idx, v);
    @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(int lim);
    // mostly inside the map, now and then anywhere on the grid
    if ($urandom_range(0, 9) == 0) return COORD_W'($urandom_range(0, GRID_SIDE - 1));
    return COORD_W'($urandom_range(0, lim - 1));
  endfunction

  // big: map is 64 by 64, so keep searches short to bound the run time
  task automatic run_mix(input int n, input bit big);
    int r, len, sx, sy, gx, gy;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_request(OP_WRITE, pick_coord(sb.map_w), pick_coord(sb.map_h),
                     COORD_W'($urandom), COORD_W'($urandom),
                     big ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 9) < 3),
                     NODE_W'($urandom));
      end else if (r < 67) begin
        if (big) begin
          sx = $urandom_range(20, 57);
          sy = $urandom_range(20, 57);
          gx = sx + $urandom_range(0, 6);
          gy = sy + $urandom_range(0, 6);
        end else begin
          sx = pick_coord(sb.map_w);
          sy = pick_coord(sb.map_h);
          gx = pick_coord(sb.map_w);
          gy = pick_coord(sb.map_h);
          if ($urandom_range(0, 9) == 0) begin
            gx = sx;
            gy = sy;
          end
        end
        send_request(OP_SEARCH, COORD_W'(sx), COORD_W'(sy), COORD_W'(gx), COORD_W'(gy),
                     1'($urandom), NODE_W'($urandom));
      end else if (r < 95) begin
        len = sb.path.size();
        send_request(OP_READ, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom), 1'($urandom),
                     NODE_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, CELLS - 1)
                                                         : $urandom_range(0, len + 1)));
      end else begin
        send_request(OP_UNUSED, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom), 1'($urandom), NODE_W'($urandom));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_WRITE;
    in_x = '0;
    in_y = '0;
    in_goal_x = '0;
    in_goal_y = '0;
    in_blocked = 1'b0;
    in_path_index = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_wdata = '0;
    idle_on = 1'b1;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty path, field extremes, walls, forced-walkable ends
    send_request(OP_READ, 0, 0, 0, 0, 0, 0);
    send_request(OP_READ, 63, 63, 63, 63, 1, CELLS - 1);
    send_request(OP_UNUSED, 63, 63, 63, 63, 1, CELLS - 1);
    send_request(OP_WRITE, 63, 63, 0, 0, 1, 0);
    send_request(OP_WRITE, 0, 0, 63, 63, 0, CELLS - 1);
    send_request(OP_SEARCH, 0, 0, 0, 0, 0, 0);
    send_request(OP_SEARCH, 0, 0, 4, 3, 0, 0);
    send_request(OP_READ, 0, 0, 0, 0, 0, 0);
    send_request(OP_READ, 0, 0, 0, 0, 0, 7);
    send_request(OP_READ, 0, 0, 0, 0, 0, 8);
    send_request(OP_WRITE, 2, 0, 0, 0, 1, 0);
    send_request(OP_WRITE, 2, 1, 0, 0, 1, 0);
    send_request(OP_WRITE, 2, 2, 0, 0, 1, 0);
    send_request(OP_SEARCH, 0, 0, 4, 0, 0, 0);
    send_request(OP_READ, 0, 0, 0, 0, 0, 5);
    send_request(OP_SEARCH, 0, 0, 2, 1, 0, 0);
    send_request(OP_WRITE, 0, 0, 0, 0, 1, 0);
    send_request(OP_SEARCH, 0, 0, 1, 2, 0, 0);
    send_request(OP_SEARCH, 63, 63, 60, 62, 0, 0);
    send_request(OP_READ, 0, 0, 0, 0, 0, 6);
    send_request(OP_SEARCH, 62, 61, 63, 63, 0, 0);
    run_mix(40, 1);
    drain();

    write_dim(CFG_WIDTH, 16);
    write_dim(CFG_HEIGHT, 16);
    run_mix(500, 0);
    idle_on = 1'b0;
    run_mix(200, 0);
    drain();

    idle_on = 1'b1;
    write_dim(CFG_WIDTH, 8);
    write_dim(CFG_HEIGHT, 8);
    run_mix(400, 0);
    drain();

    write_dim(CFG_WIDTH, 5);
    write_dim(CFG_HEIGHT, 12);
    run_mix(200, 0);
    drain();

    write_dim(CFG_WIDTH, 127);
    write_dim(CFG_HEIGHT, 4);
    run_mix(150, 0);
    drain();

    write_dim(CFG_WIDTH, 1);
    write_dim(CFG_HEIGHT, 64);
    run_mix(100, 0);
    drain();

    write_dim(CFG_WIDTH, 0);
    write_dim(CFG_HEIGHT, 0);
    run_mix(30, 0);
    drain();

    idle_on = 1'b0;
    write_dim(CFG_WIDTH, 64);
    write_dim(CFG_HEIGHT, 64);
    run_mix(60, 1);
    drain();

    $display("Ran %0d searches (%0d found a path) and %0d in-range path reads,",
             sb.searches, sb.found_paths, sb.valid_reads);
    $display("over map sizes from 1x1 to 64x64, with %0d mismatches.", sb.errors);
    if (sb.errors == 0) begin
      $display("grid_astar_path_search test passed");
    end else begin
      $display("grid_astar_path_search test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/gasp_pkg.sv
rtl/gasp_store.sv
rtl/gasp_seq.sv
rtl/grid_astar_path_search.sv
tb/grid_astar_path_search_tb.sv
